// ===== sv/obd2pqe_pkg.sv =====
// ----------------------------------------------------------------------------
// obd2pqe_pkg
// Types, identifiers and codes shared by the OBD2 PID query engine.
// ----------------------------------------------------------------------------
package obd2pqe_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned ID_W        = 29;
  localparam int unsigned PAYLOAD_W   = 8 * FRAME_BYTES;
  localparam int unsigned TICK_W      = 16;

  localparam logic [ID_W-1:0] STD_REQ_ID = 29'h7DF;
  localparam logic [ID_W-1:0] STD_RSP_ID = 29'h7E8;
  localparam logic [ID_W-1:0] EXT_REQ_ID = 29'h18DB33F1;
  localparam logic [ID_W-1:0] EXT_RSP_ID = 29'h18DAF111;

  localparam logic [7:0]        REQ_LEN_BYTE  = 8'd2;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd50;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 144;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_EXT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_FRAME   = 2'd1,
    ACT_TICK    = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_FRAME   = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WAIT = 1'b1
  } state_e;

  typedef struct packed {
    logic              use_ext;
    logic [TICK_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    op_e                  op;
    logic [7:0]           mode;
    logic [7:0]           pid;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   full;
    logic   head_valid;
    entry_t head;
  } qstat_t;

  typedef struct packed {
    kind_e                kind;
    logic [ID_W-1:0]      tx_id;
    logic                 tx_extended;
    logic [PAYLOAD_W-1:0] tx_payload;
    logic [LEN_W-1:0]     tx_length;
    logic [7:0]           byte_a;
    logic [7:0]           byte_b;
    logic [7:0]           byte_c;
    logic [7:0]           byte_d;
    logic signed [8:0]    data_length;
  } result_t;

endpackage

// ===== sv/obd2pqe_front.sv =====
// ----------------------------------------------------------------------------
// obd2pqe_front
// Accepts input transfers, drops unused codes and foreign frames, and turns
// the rest into queue entries.
// ----------------------------------------------------------------------------
module obd2pqe_front
  import obd2pqe_pkg::*;
(
  input  cfg_t                  cfg_i,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [1:0]            action_i,
  input  logic [7:0]            mode_i,
  input  logic [7:0]            pid_i,
  input  logic [ID_W-1:0]       rx_id_i,
  input  logic                  rx_extended_i,
  input  logic [LEN_W-1:0]      rx_length_i,
  input  logic [PAYLOAD_W-1:0]  rx_payload_i,
  input  qstat_t                qstat_i,
  output logic                  push_o,
  output entry_t                push_entry_o
);

  logic [ID_W-1:0] rsp_id;
  logic            frame_match;
  logic            keep;

  assign s_ready_o   = !qstat_i.full;
  assign rsp_id      = cfg_i.use_ext ? EXT_RSP_ID : STD_RSP_ID;
  assign frame_match = (rx_id_i == rsp_id) && (rx_extended_i == cfg_i.use_ext);

  always_comb begin
    keep              = 1'b0;
    push_entry_o.op   = OP_TICK;
    unique case (action_i)
      ACT_REQUEST: begin
        keep            = 1'b1;
        push_entry_o.op = OP_REQUEST;
      end
      ACT_FRAME: begin
        keep            = frame_match;
        push_entry_o.op = OP_FRAME;
      end
      ACT_TICK: begin
        keep            = 1'b1;
        push_entry_o.op = OP_TICK;
      end
      default: begin
        keep            = 1'b0;
        push_entry_o.op = OP_TICK;
      end
    endcase
  end

  assign push_entry_o.mode    = mode_i;
  assign push_entry_o.pid     = pid_i;
  assign push_entry_o.len     = rx_length_i;
  assign push_entry_o.payload = rx_payload_i;
  assign push_o               = s_valid_i && s_ready_o && keep;

endmodule

// ===== sv/obd2pqe_queue.sv =====
// ----------------------------------------------------------------------------
// obd2pqe_queue
// Short register queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module obd2pqe_queue
  import obd2pqe_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output qstat_t qstat_o
);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign qstat_o.full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.head_valid = (cnt_q != '0);
  assign qstat_o.head       = mem_q[rd_ptr_q];

endmodule

// ===== sv/obd2pqe_back.sv =====
// ----------------------------------------------------------------------------
// obd2pqe_back
// Executes queued entries against the wait state, tick counter and payload
// store, and holds the result in an output register.
// ----------------------------------------------------------------------------
module obd2pqe_back
  import obd2pqe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  qstat_t  qstat_i,
  output logic    pop_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_result_o
);

  state_e            state_q, state_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [7:0]        store_q [FRAME_BYTES];
  logic [7:0]        store_d [FRAME_BYTES];
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              load_ok;
  logic              produce;
  logic              store_we;
  logic [TICK_W-1:0] tick_inc;
  logic              timed_out;
  kind_e             res_kind;
  entry_t            head;

  assign head      = qstat_i.head;
  assign load_ok   = !out_valid_q || m_ready_i;
  assign tick_inc  = (tick_q < TICK_MAX) ? tick_q + 1'b1 : tick_q;
  assign timed_out = (tick_inc >= cfg_i.timeout);

  // Result decision
  always_comb begin
    produce  = 1'b0;
    res_kind = KIND_TX;
    unique case (head.op)
      OP_REQUEST: begin
        produce  = (state_q == ST_IDLE);
        res_kind = KIND_TX;
      end
      OP_FRAME: begin
        produce  = (state_q == ST_WAIT);
        res_kind = KIND_REPLY;
      end
      OP_TICK: begin
        produce  = (state_q == ST_WAIT) && timed_out;
        res_kind = KIND_ABORT;
      end
      default: begin
        produce  = 1'b0;
        res_kind = KIND_TX;
      end
    endcase
  end

  assign pop_o    = qstat_i.head_valid && (!produce || load_ok);
  assign store_we = pop_o && (head.op == OP_FRAME) && (state_q == ST_WAIT);

  // Next state
  always_comb begin
    state_d = state_q;
    if (pop_o && produce) begin
      state_d = (res_kind == KIND_TX) ? ST_WAIT : ST_IDLE;
    end
  end

  // Datapath outputs
  always_comb begin
    tick_d = tick_q;
    if (pop_o && head.op == OP_REQUEST && state_q == ST_IDLE) begin
      tick_d = '0;
    end else if (pop_o && head.op == OP_TICK && state_q == ST_WAIT) begin
      tick_d = tick_inc;
    end

    for (int i = 0; i < FRAME_BYTES; i++) begin
      store_d[i] = store_q[i];
      if (store_we && (LEN_W'(i) < head.len)) begin
        store_d[i] = head.payload[8*i +: 8];
      end
    end

    out_d      = '0;
    out_d.kind = res_kind;
    unique case (res_kind)
      KIND_TX: begin
        out_d.tx_id       = cfg_i.use_ext ? EXT_REQ_ID : STD_REQ_ID;
        out_d.tx_extended = cfg_i.use_ext;
        out_d.tx_payload  = {40'd0, head.pid, head.mode, REQ_LEN_BYTE};
        out_d.tx_length   = LEN_W'(FRAME_BYTES);
      end
      KIND_REPLY: begin
        out_d.byte_a      = store_d[3];
        out_d.byte_b      = store_d[4];
        out_d.byte_c      = store_d[5];
        out_d.byte_d      = store_d[6];
        out_d.data_length = $signed({1'b0, store_d[0]} - 9'd2);
      end
      default: begin
        out_d.tx_length = '0;
      end
    endcase

    out_valid_d = out_valid_q;
    if (load_ok) begin
      out_valid_d = pop_o && produce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= store_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && pop_o && produce) begin
      out_q <= out_d;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

endmodule

// ===== sv/obd2_pid_query_engine_unit.sv =====
// ----------------------------------------------------------------------------
// obd2_pid_query_engine_unit
// Path: input transfer, queue register, output register, result valid.
// Throughput: one input transfer per cycle while the queue is not full; the
// 2-entry queue and output register let input and output stall independently.
// Reset: async active low; idle, tick count zero, payload store zero,
// 11-bit ids selected, timeout 50 ticks.
// ----------------------------------------------------------------------------
module obd2_pid_query_engine_unit
  import obd2pqe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: mode[7:0] pid[15:8] rx_id[44:16] rx_extended[45]
  //        rx_length[49:46] rx_payload[113:50], zero pad [119:114]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: tx_id[28:0] tx_extended[29] tx_payload[93:30] tx_length[97:94]
  //        byte_a[105:98] byte_b[113:106] byte_c[121:114] byte_d[129:122]
  //        data_length[138:130], zero pad [143:139]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]             m_axis_tuser
);

  cfg_t    cfg_q;
  qstat_t  qstat;
  logic    push;
  entry_t  push_entry;
  logic    pop;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_ext <= 1'b0;
      cfg_q.timeout <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USE_EXT: cfg_q.use_ext <= cfg_wdata_i[0];
        CFG_TIMEOUT: cfg_q.timeout <= cfg_wdata_i[TICK_W-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  obd2pqe_front u_front (
    .cfg_i         (cfg_q),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .action_i      (s_axis_tuser),
    .mode_i        (s_axis_tdata[7:0]),
    .pid_i         (s_axis_tdata[15:8]),
    .rx_id_i       (s_axis_tdata[44:16]),
    .rx_extended_i (s_axis_tdata[45]),
    .rx_length_i   (s_axis_tdata[49:46]),
    .rx_payload_i  (s_axis_tdata[113:50]),
    .qstat_i       (qstat),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  obd2pqe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .qstat_o      (qstat)
  );

  obd2pqe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tuser = result.kind;
  assign m_axis_tdata = {5'd0, result.data_length, result.byte_d, result.byte_c,
                         result.byte_b, result.byte_a, result.tx_length,
                         result.tx_payload, result.tx_extended, result.tx_id};

endmodule

// ===== sv/obd2pqe_checker.sv =====
// ----------------------------------------------------------------------------
// obd2pqe_checker
// Port-level checks on the result stream of the query engine.
// ----------------------------------------------------------------------------
module obd2pqe_checker
  import obd2pqe_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_TX) || (m_axis_tuser == KIND_REPLY) ||
                      (m_axis_tuser == KIND_ABORT))
    else $error("unknown result kind");

  a_tx_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_TX |->
      m_axis_tdata[37:30] == REQ_LEN_BYTE && m_axis_tdata[93:54] == '0 &&
      m_axis_tdata[97:94] == 4'd8 && m_axis_tdata[143:98] == '0)
    else $error("malformed transmit frame");

  a_reply_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_TX |-> m_axis_tdata[97:0] == '0)
    else $error("transmit fields set on non-transmit result");

endmodule

bind obd2_pid_query_engine_unit obd2pqe_checker u_obd2pqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
